// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL; clocked on aclk, idle while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PSAT_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("psat: assertion failed");

// Next-cycle implication.
`define PSAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("psat: assertion failed");

`endif

// ===== rtl/psat_pkg.sv =====
`timescale 1ns / 1ps
package psat_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int MAX_VERTICES_DEF = 16;

    localparam int COORD_W   = 32;
    localparam int VTX_W     = 2 * COORD_W;
    localparam int NORM_W    = 18;
    localparam int PEN_W     = 31;
    localparam int STAT_W    = 2;
    localparam int OP_W      = 2;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int MAG_W     = COORD_W - 1;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SQ_W      = 64;
    localparam int LEN_W     = SQ_W / 2;
    localparam int QUOT_W    = FRAC_BITS + 1;
    localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
    localparam int ACC_W     = 50;
    localparam int PROJ_W    = ACC_W - FRAC_BITS;
    localparam int PENC_W    = PROJ_W + 2;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    localparam logic [PEN_W-1:0]         PEN_MAX  = {PEN_W{1'b1}};
    localparam logic signed [NORM_W-1:0] NORM_ONE = NORM_W'(1 << FRAC_BITS);

    typedef enum logic [OP_W-1:0] {
        OP_VTX_FIRST  = 2'd0,
        OP_VTX_SECOND = 2'd1,
        OP_POS_FIRST  = 2'd2,
        OP_START      = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_FEW      = 2'd2
    } status_t;

endpackage

// ===== rtl/polygon_separating_axis_test.sv =====
`timescale 1ns / 1ps
// Separating-axis collision test for two convex polygons in signed Q16.16. Load the
// vertices of the first polygon (operation 0) and of the second (operation 1) one per
// transfer, in winding order, up to MAX_VERTICES each; set the first polygon's position
// with operation 2; the transfer with operation 3 carries the second position and
// starts the test, and produces the only result transfer. The operation travels on
// s_tuser. The test walks the edges of the first polygon, then of the second; per
// non-degenerate edge it squares the edge components on the shared 33x33 multiplier,
// takes a bit-serial square root and two restoring divisions for the unit axis, then
// projects every vertex of both polygons; a gap ends the walk early. The input side is
// not ready while a test runs. After each start both vertex counts and the overflow
// flag are cleared; the first position is kept.

`include "assert_macros.svh"

module polygon_separating_axis_test
    import psat_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] coord_x, [63:32] coord_y
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] colliding, [31:1] penetration, [49:32] normal_x, [67:50] normal_y,
    // [69:68] status, [71:70] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int IW = $clog2(MAX_VERTICES);

    typedef enum logic [19:0] {
        ST_IDLE   = 20'h00001,
        ST_E_RD0  = 20'h00002,
        ST_E_RD1  = 20'h00004,
        ST_E_CALC = 20'h00008,
        ST_SQ_A   = 20'h00010,
        ST_SQ_B   = 20'h00020,
        ST_SQ_C   = 20'h00040,
        ST_SQRT   = 20'h00080,
        ST_DIV_A  = 20'h00100,
        ST_DIV_B  = 20'h00200,
        ST_P_RD   = 20'h00400,
        ST_P_X    = 20'h00800,
        ST_P_Y    = 20'h01000,
        ST_P_SUM  = 20'h02000,
        ST_CHECK  = 20'h04000,
        ST_E_NEXT = 20'h08000,
        ST_FIN    = 20'h10000,
        ST_FL_B   = 20'h20000,
        ST_FL_C   = 20'h40000,
        ST_DONE   = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    // input transfer decode
    logic                      s_xfer;
    op_t                       s_op;
    logic signed [COORD_W-1:0] s_x, s_y;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign s_op     = op_t'(s_tuser);
    assign s_x      = s_tdata[COORD_W-1:0];
    assign s_y      = s_tdata[VTX_W-1:COORD_W];

    // vertex stores and their fill counts
    logic [VTX_W-1:0] fst_mem [MAX_VERTICES];
    logic [VTX_W-1:0] sec_mem [MAX_VERTICES];
    logic [VTX_W-1:0] fst_q_reg, sec_q_reg, rd_data;
    logic [IW-1:0]    rd_addr;
    logic             rd_sel, rd_sel_reg;
    logic [CW-1:0]    fst_cnt_reg, sec_cnt_reg;
    logic             ovf_reg;
    logic             wr_fst, wr_sec;

    assign wr_fst = s_xfer && (s_op == OP_VTX_FIRST) && (fst_cnt_reg < CW'(MAX_VERTICES));
    assign wr_sec = s_xfer && (s_op == OP_VTX_SECOND) && (sec_cnt_reg < CW'(MAX_VERTICES));

    always_ff @(posedge aclk) begin
        if (wr_fst) begin
            fst_mem[fst_cnt_reg[IW-1:0]] <= {s_y, s_x};
        end
        if (wr_sec) begin
            sec_mem[sec_cnt_reg[IW-1:0]] <= {s_y, s_x};
        end
        fst_q_reg  <= fst_mem[rd_addr];
        sec_q_reg  <= sec_mem[rd_addr];
        rd_sel_reg <= rd_sel;
    end

    logic signed [COORD_W-1:0] rd_x, rd_y;

    assign rd_data = rd_sel_reg ? sec_q_reg : fst_q_reg;
    assign rd_x    = rd_data[COORD_W-1:0];
    assign rd_y    = rd_data[VTX_W-1:COORD_W];

    // positions
    logic signed [COORD_W-1:0] pos_x_reg, pos_y_reg, sp_x_reg, sp_y_reg;

    // edge walk
    logic                      edge_poly_reg;
    logic [IW-1:0]             edge_idx_reg, edge_j;
    logic [CW-1:0]             ecnt, edge_inc;
    logic signed [COORD_W-1:0] vi_x_reg, vi_y_reg;
    logic signed [EDGE_W-1:0]  ex, ey;
    logic [EDGE_W-1:0]         ma0, mb0, mag_or;
    logic [MAG_W-1:0]          ma_c, mb_c, ma_reg, mb_reg;
    logic                      ey_pos_reg, ex_neg_reg;
    logic [SQ_W-2:0]           sq_reg;

    assign ecnt     = edge_poly_reg ? sec_cnt_reg : fst_cnt_reg;
    assign edge_inc = CW'(edge_idx_reg) + CW'(1);
    assign edge_j   = (edge_inc < ecnt) ? edge_inc[IW-1:0] : '0;

    // edge vector from the held start vertex and the vertex now on the read port
    assign ex     = EDGE_W'(rd_x) - EDGE_W'(vi_x_reg);
    assign ey     = EDGE_W'(rd_y) - EDGE_W'(vi_y_reg);
    assign ma0    = (ey < 0) ? EDGE_W'(-ey) : EDGE_W'(ey);
    assign mb0    = (ex < 0) ? EDGE_W'(-ex) : EDGE_W'(ex);
    assign mag_or = ma0 | mb0;

    // halve both until neither reaches 2^31: at most two shifts
    always_comb begin
        priority if (mag_or[EDGE_W-1]) begin
            ma_c = ma0[EDGE_W-1:2];
            mb_c = mb0[EDGE_W-1:2];
        end else if (mag_or[EDGE_W-2]) begin
            ma_c = ma0[EDGE_W-2:1];
            mb_c = mb0[EDGE_W-2:1];
        end else begin
            ma_c = ma0[MAG_W-1:0];
            mb_c = mb0[MAG_W-1:0];
        end
    end

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    psat_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // square root and divider
    logic             sqrt_start, sqrt_done;
    logic [SQ_W-1:0]  sqrt_in;
    logic [LEN_W-1:0] len;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [QUOT_W-1:0] quot;

    assign sqrt_start = (state_reg == ST_SQ_C);
    assign sqrt_in    = SQ_W'(sq_reg) + SQ_W'(prod[SQ_W-2:0]);

    psat_sqrt #(.IN_W(SQ_W)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (sqrt_in),
        .done    (sqrt_done),
        .root    (len)
    );

    // first division starts when the root lands, the second when the first ends
    assign div_start = ((state_reg == ST_SQRT) || (state_reg == ST_DIV_A)) &&
                       (sqrt_done || div_done) ;
    assign div_num   = (NUM_W'((state_reg == ST_SQRT) ? ma_reg : mb_reg) << FRAC_BITS) +
                       NUM_W'(len >> 1);

    psat_div #(.N_W(NUM_W), .D_W(LEN_W), .Q_W(QUOT_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (len),
        .done    (div_done),
        .quot    (quot)
    );

    // projection walk
    logic signed [NORM_W-1:0]  nx_reg, ny_reg, bnx_reg, bny_reg;
    logic signed [NORM_W-1:0]  q_signed;
    logic                      proj_poly_reg;
    logic [IW-1:0]             proj_idx_reg;
    logic [CW-1:0]             pcnt, proj_inc;
    logic signed [COORD_W-1:0] vy_reg;
    logic signed [ACC_W-1:0]   acc_reg, sum;
    logic signed [PROJ_W-1:0]  proj;
    logic signed [PROJ_W-1:0]  min_a_reg, max_a_reg, min_b_reg, max_b_reg;
    logic signed [PENC_W-1:0]  pen_ab, pen_ba, pen;
    logic                      gap;
    logic                      found_reg;
    logic signed [PENC_W-1:0]  best_reg;
    logic signed [EDGE_W-1:0]  dx, dy;

    assign q_signed = NORM_W'(quot);
    assign pcnt     = proj_poly_reg ? sec_cnt_reg : fst_cnt_reg;
    assign proj_inc = CW'(proj_idx_reg) + CW'(1);
    assign sum      = acc_reg + ACC_W'(prod);
    assign proj     = PROJ_W'(sum >>> FRAC_BITS);
    assign gap      = (min_a_reg >= max_b_reg) || (min_b_reg >= max_a_reg);
    assign pen_ab   = PENC_W'(max_a_reg) - PENC_W'(min_b_reg);
    assign pen_ba   = PENC_W'(max_b_reg) - PENC_W'(min_a_reg);
    assign pen      = (pen_ba < pen_ab) ? pen_ba : pen_ab;
    assign dx       = EDGE_W'(sp_x_reg) - EDGE_W'(pos_x_reg);
    assign dy       = EDGE_W'(sp_y_reg) - EDGE_W'(pos_y_reg);

    // result registers
    logic             res_coll_reg;
    logic [PEN_W-1:0] res_pen_reg;
    logic [NORM_W-1:0] res_nx_reg, res_ny_reg;
    status_t          res_stat_reg;
    logic             m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // read port and multiplier steering
    always_comb begin
        rd_addr = '0;
        rd_sel  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            ST_E_RD0: begin
                rd_addr = edge_idx_reg;
                rd_sel  = edge_poly_reg;
            end
            ST_E_RD1: begin
                rd_addr = edge_j;
                rd_sel  = edge_poly_reg;
            end
            ST_P_RD: begin
                rd_addr = proj_idx_reg;
                rd_sel  = proj_poly_reg;
            end
            ST_SQ_A: begin
                mul_a = MUL_W'(ma_reg);
                mul_b = MUL_W'(ma_reg);
            end
            ST_SQ_B: begin
                mul_a = MUL_W'(mb_reg);
                mul_b = MUL_W'(mb_reg);
            end
            ST_P_X: begin
                mul_a = MUL_W'(rd_x);
                mul_b = MUL_W'(nx_reg);
            end
            ST_P_Y: begin
                mul_a = MUL_W'(vy_reg);
                mul_b = MUL_W'(ny_reg);
            end
            ST_FIN: begin
                mul_a = MUL_W'(dx);
                mul_b = MUL_W'(bnx_reg);
            end
            ST_FL_B: begin
                mul_a = MUL_W'(dy);
                mul_b = MUL_W'(bny_reg);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (s_op == OP_START)) begin
                    if (ovf_reg || (fst_cnt_reg < CW'(3)) || (sec_cnt_reg < CW'(3))) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_E_RD0;
                    end
                end
            end
            ST_E_RD0:  state_next = ST_E_RD1;
            ST_E_RD1:  state_next = ST_E_CALC;
            ST_E_CALC: state_next = (mag_or == '0) ? ST_E_NEXT : ST_SQ_A;
            ST_SQ_A:   state_next = ST_SQ_B;
            ST_SQ_B:   state_next = ST_SQ_C;
            ST_SQ_C:   state_next = ST_SQRT;
            ST_SQRT:   state_next = sqrt_done ? ST_DIV_A : ST_SQRT;
            ST_DIV_A:  state_next = div_done ? ST_DIV_B : ST_DIV_A;
            ST_DIV_B:  state_next = div_done ? ST_P_RD : ST_DIV_B;
            ST_P_RD:   state_next = ST_P_X;
            ST_P_X:    state_next = ST_P_Y;
            ST_P_Y:    state_next = ST_P_SUM;
            ST_P_SUM: begin
                if ((proj_inc == pcnt) && proj_poly_reg) begin
                    state_next = ST_CHECK;
                end else begin
                    state_next = ST_P_RD;
                end
            end
            ST_CHECK:  state_next = gap ? ST_DONE : ST_E_NEXT;
            ST_E_NEXT: begin
                if ((edge_inc == ecnt) && edge_poly_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_E_RD0;
                end
            end
            ST_FIN:    state_next = found_reg ? ST_FL_B : ST_DONE;
            ST_FL_B:   state_next = ST_FL_C;
            ST_FL_C:   state_next = ST_DONE;
            ST_DONE:   state_next = (!m_tvalid_reg || m_tready) ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state: sequencer, fill counts, overflow flag, first position, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fst_cnt_reg  <= '0;
            sec_cnt_reg  <= '0;
            ovf_reg      <= 1'b0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (wr_fst) begin
                fst_cnt_reg <= fst_cnt_reg + CW'(1);
            end
            if (wr_sec) begin
                sec_cnt_reg <= sec_cnt_reg + CW'(1);
            end
            // a vertex that finds its store full is dropped and flagged
            if (s_xfer && !wr_fst && !wr_sec &&
                ((s_op == OP_VTX_FIRST) || (s_op == OP_VTX_SECOND))) begin
                ovf_reg <= 1'b1;
            end
            if (s_xfer && (s_op == OP_POS_FIRST)) begin
                pos_x_reg <= s_x;
                pos_y_reg <= s_y;
            end
            // hand over the result and clear the loaded polygons
            if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
                fst_cnt_reg  <= '0;
                sec_cnt_reg  <= '0;
                ovf_reg      <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (s_op == OP_START)) begin
                    sp_x_reg      <= s_x;
                    sp_y_reg      <= s_y;
                    edge_poly_reg <= 1'b0;
                    edge_idx_reg  <= '0;
                    found_reg     <= 1'b0;
                    res_coll_reg  <= 1'b0;
                    res_pen_reg   <= '0;
                    res_nx_reg    <= '0;
                    res_ny_reg    <= '0;
                    priority if (ovf_reg) begin
                        res_stat_reg <= STAT_OVERFLOW;
                    end else if ((fst_cnt_reg < CW'(3)) || (sec_cnt_reg < CW'(3))) begin
                        res_stat_reg <= STAT_FEW;
                    end else begin
                        res_stat_reg <= STAT_OK;
                    end
                end
            end
            ST_E_RD1: begin
                vi_x_reg <= rd_x;
                vi_y_reg <= rd_y;
            end
            ST_E_CALC: begin
                ma_reg     <= ma_c;
                mb_reg     <= mb_c;
                ey_pos_reg <= (ey > 0);
                ex_neg_reg <= (ex < 0);
            end
            ST_SQ_B: begin
                sq_reg <= prod[SQ_W-2:0];
            end
            ST_DIV_A: begin
                if (div_done) begin
                    nx_reg <= ey_pos_reg ? -q_signed : q_signed;
                end
            end
            ST_DIV_B: begin
                if (div_done) begin
                    ny_reg        <= ex_neg_reg ? -q_signed : q_signed;
                    proj_poly_reg <= 1'b0;
                    proj_idx_reg  <= '0;
                end
            end
            ST_P_X: begin
                vy_reg <= rd_y;
            end
            ST_P_Y: begin
                acc_reg <= ACC_W'(prod);
            end
            ST_P_SUM: begin
                if (!proj_poly_reg) begin
                    if ((proj_idx_reg == '0) || (proj < min_a_reg)) begin
                        min_a_reg <= proj;
                    end
                    if ((proj_idx_reg == '0) || (proj > max_a_reg)) begin
                        max_a_reg <= proj;
                    end
                end else begin
                    if ((proj_idx_reg == '0) || (proj < min_b_reg)) begin
                        min_b_reg <= proj;
                    end
                    if ((proj_idx_reg == '0) || (proj > max_b_reg)) begin
                        max_b_reg <= proj;
                    end
                end
                if (proj_inc == pcnt) begin
                    proj_poly_reg <= 1'b1;
                    proj_idx_reg  <= '0;
                end else begin
                    proj_idx_reg <= proj_inc[IW-1:0];
                end
            end
            ST_CHECK: begin
                // a gap ends the test with the cleared no-collision result
                if (!gap && (!found_reg || (pen < best_reg))) begin
                    found_reg <= 1'b1;
                    best_reg  <= pen;
                    bnx_reg   <= nx_reg;
                    bny_reg   <= ny_reg;
                end
            end
            ST_E_NEXT: begin
                if (edge_inc == ecnt) begin
                    edge_poly_reg <= 1'b1;
                    edge_idx_reg  <= '0;
                end else begin
                    edge_idx_reg <= edge_inc[IW-1:0];
                end
            end
            ST_FIN: begin
                // no axis at all: colliding with the largest penetration
                if (!found_reg) begin
                    res_coll_reg <= 1'b1;
                    res_pen_reg  <= PEN_MAX;
                end
            end
            ST_FL_B: begin
                acc_reg <= ACC_W'(prod);
            end
            ST_FL_C: begin
                res_coll_reg <= 1'b1;
                res_pen_reg  <= (best_reg > PENC_W'(PEN_MAX)) ? PEN_MAX : best_reg[PEN_W-1:0];
                if (sum < 0) begin
                    res_nx_reg <= -bnx_reg;
                    res_ny_reg <= -bny_reg;
                end else begin
                    res_nx_reg <= bnx_reg;
                    res_ny_reg <= bny_reg;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= {2'b00, res_stat_reg, res_ny_reg, res_nx_reg,
                                    res_pen_reg, res_coll_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PSAT_ASSERT(a_cnt_bound, 1'b1, (fst_cnt_reg <= CW'(MAX_VERTICES)) && (sec_cnt_reg <= CW'(MAX_VERTICES)))
    `PSAT_ASSERT(a_no_store_wr_busy, state_reg != ST_IDLE, !(wr_fst || wr_sec))
    `PSAT_ASSERT(a_unit_axis, state_reg == ST_P_RD, (nx_reg <= NORM_ONE) && (nx_reg >= -NORM_ONE) && (ny_reg <= NORM_ONE) && (ny_reg >= -NORM_ONE))
    `PSAT_ASSERT_NEXT(a_result_out, (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready), m_tvalid_reg && (state_reg == ST_IDLE))

endmodule

// ===== rtl/psat_mul.sv =====
`timescale 1ns / 1ps
module psat_mul
    import psat_pkg::*;
(
    input  logic                     aclk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // registered signed product
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/psat_sqrt.sv =====
`timescale 1ns / 1ps
module psat_sqrt
    import psat_pkg::*;
#(
    parameter int IN_W = SQ_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [IN_W-1:0]   operand,
    output logic              done,
    output logic [IN_W/2-1:0] root
);

    localparam int CNT_W = $clog2(IN_W / 2 + 1);

    logic [IN_W-1:0]  v_reg, res_reg, bit_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg, done_reg;
    logic [IN_W-1:0]  trial;

    assign trial = res_reg + bit_reg;

    // one result bit per cycle, floor square root
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(IN_W / 2);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= operand;
            res_reg <= '0;
            bit_reg <= IN_W'(1) << (IN_W - 2);
        end else if (run_reg) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[IN_W/2-1:0];

endmodule

// ===== rtl/psat_div.sv =====
`timescale 1ns / 1ps
module psat_div
    import psat_pkg::*;
#(
    parameter int N_W = NUM_W,
    parameter int D_W = LEN_W,
    parameter int Q_W = QUOT_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] numer,
    input  logic [D_W-1:0] denom,
    output logic           done,
    output logic [Q_W-1:0] quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [D_W-1:0]   rem_reg, den_reg;
    logic [N_W-1:0]   num_reg;
    logic [Q_W-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg, done_reg;
    logic [D_W:0]     trial;

    // quotient known to fit Q_W bits, so the top of the numerator is already below denom
    assign trial = {rem_reg, num_reg[N_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(Q_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= D_W'(numer >> Q_W);
            num_reg <= numer << (N_W - Q_W);
            den_reg <= denom;
            q_reg   <= '0;
        end else if (run_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_reg <= D_W'(trial - {1'b0, den_reg});
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[D_W-1:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
            num_reg <= num_reg << 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for polygon_separating_axis_test: a queue of load and start transfers drives the
// slave side; an in-bench predictor works out each collision result when the start transfer
// is taken, and the monitor checks every master-side transfer against the oldest one.

module tb_top;
    import psat_pkg::*;

    localparam int NV = MAX_VERTICES_DEF;

    // field order mirrors m_tdata, highest field first
    typedef struct packed {
        logic [STAT_W-1:0]         status;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_x;
        logic [PEN_W-1:0]          penetration;
        logic                      colliding;
    } contact_t;

    typedef struct packed {
        op_t                       op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } load_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    polygon_separating_axis_test dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stimulus and expected contacts
    load_t    pending_loads[$];
    contact_t expected_contacts[$];
    int       errors = 0;
    int       total_loads = 0;
    int       taken_loads = 0;
    int       contacts_seen = 0;
    int       hits_seen = 0;
    int       fault_seen = 0;

    // Shadow copy of the block's state
    logic signed [COORD_W-1:0] a_x[NV], a_y[NV], b_x[NV], b_y[NV];
    int unsigned               a_cnt = 0, b_cnt = 0;
    logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0;
    bit                        spill = 1'b0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Projection extent of one polygon on axis (nx, ny); floor shift of the dot product.
    function automatic void extent(bit second, longint nx, longint ny,
                                   output longint lo, output longint hi);
        int unsigned cnt = second ? b_cnt : a_cnt;
        longint      p;
        lo = 0;
        hi = 0;
        for (int i = 0; i < cnt; i++) begin
            if (second) p = (longint'(b_x[i]) * nx + longint'(b_y[i]) * ny) >>> FRAC_BITS;
            else        p = (longint'(a_x[i]) * nx + longint'(a_y[i]) * ny) >>> FRAC_BITS;
            if (i == 0 || p < lo) lo = p;
            if (i == 0 || p > hi) hi = p;
        end
    endfunction

    // Walk the edge axes of one polygon; return 0 on a separating gap.
    function automatic bit edge_axes(bit second, inout bit found, inout longint best,
                                     inout longint bnx, inout longint bny);
        int unsigned     cnt = second ? b_cnt : a_cnt;
        int unsigned     j;
        longint          ex, ey, nx, ny, lo_a, hi_a, lo_b, hi_b, pen;
        longint unsigned ma, mb, len, ua, ub;
        for (int i = 0; i < cnt; i++) begin
            j = (i + 1 < cnt) ? i + 1 : 0;
            if (second) begin
                ex = longint'(b_x[j]) - longint'(b_x[i]);
                ey = longint'(b_y[j]) - longint'(b_y[i]);
            end else begin
                ex = longint'(a_x[j]) - longint'(a_x[i]);
                ey = longint'(a_y[j]) - longint'(a_y[i]);
            end
            ma = ey < 0 ? -ey : ey;
            mb = ex < 0 ? -ex : ex;
            // skip zero-length edges
            if (ma == 0 && mb == 0) continue;
            while ((ma | mb) >= 64'h8000_0000) begin
                ma = ma >> 1;
                mb = mb >> 1;
            end
            len = root_floor(ma * ma + mb * mb);
            ua  = ((ma << FRAC_BITS) + len / 2) / len;
            ub  = ((mb << FRAC_BITS) + len / 2) / len;
            nx  = ey > 0 ? -longint'(ua) : longint'(ua);
            ny  = ex < 0 ? -longint'(ub) : longint'(ub);
            extent(1'b0, nx, ny, lo_a, hi_a);
            extent(1'b1, nx, ny, lo_b, hi_b);
            if (lo_a >= hi_b || lo_b >= hi_a) return 1'b0;
            pen = hi_a - lo_b;
            if (hi_b - lo_a < pen) pen = hi_b - lo_a;
            // ties keep the earlier axis
            if (!found || pen < best) begin
                found = 1'b1;
                best  = pen;
                bnx   = nx;
                bny   = ny;
            end
        end
        return 1'b1;
    endfunction

    // Apply one taken transfer to the shadow state; a start queues its contact.
    function automatic void track_load(load_t ld);
        contact_t c = '0;
        bit       found = 1'b0;
        longint   best = 0, bnx = 0, bny = 0, dx, dy;
        case (ld.op)
            OP_VTX_FIRST: begin
                if (a_cnt < NV) begin
                    a_x[a_cnt] = ld.x;
                    a_y[a_cnt] = ld.y;
                    a_cnt++;
                end else spill = 1'b1;
            end
            OP_VTX_SECOND: begin
                if (b_cnt < NV) begin
                    b_x[b_cnt] = ld.x;
                    b_y[b_cnt] = ld.y;
                    b_cnt++;
                end else spill = 1'b1;
            end
            OP_POS_FIRST: begin
                pos_x = ld.x;
                pos_y = ld.y;
            end
            default: begin
                if (spill) c.status = STAT_OVERFLOW;
                else if (a_cnt < 3 || b_cnt < 3) c.status = STAT_FEW;
                else if (edge_axes(1'b0, found, best, bnx, bny)
                         && edge_axes(1'b1, found, best, bnx, bny)) begin
                    c.colliding = 1'b1;
                    if (!found) c.penetration = PEN_MAX;
                    else begin
                        dx = longint'(ld.x) - longint'(pos_x);
                        dy = longint'(ld.y) - longint'(pos_y);
                        c.penetration = best > 64'sh7FFF_FFFF ? PEN_MAX : PEN_W'(best);
                        // point from first position towards second
                        if (dx * bnx + dy * bny < 0) begin
                            bnx = -bnx;
                            bny = -bny;
                        end
                        c.normal_x = NORM_W'(bnx);
                        c.normal_y = NORM_W'(bny);
                    end
                end
                expected_contacts.push_back(c);
                a_cnt = 0;
                b_cnt = 0;
                spill = 1'b0;
            end
        endcase
    endfunction

    // Idle and stall percentages follow four phases over the run.
    function automatic int idle_pct(bit receiver);
        int ph = (total_loads == 0) ? 0 : (taken_loads * 4) / total_loads;
        case (ph)
            0:       return 0;
            1:       return receiver ? 0 : 45;
            2:       return receiver ? 45 : 0;
            default: return 32;
        endcase
    endfunction

    // Driver: advance to the next pending load once the current transfer is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_load(load_t'({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
                taken_loads++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_loads.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    load_t nx_ld;
                    nx_ld = pending_loads.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nx_ld.y, nx_ld.x};
                    s_tuser  <= nx_ld.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expected contact.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                contact_t got, want;
                got = contact_t'(m_tdata[69:0]);
                contacts_seen++;
                if (expected_contacts.size() == 0) begin
                    $error("result transfer with no contact expected: %h", m_tdata);
                    errors++;
                end else begin
                    want = expected_contacts.pop_front();
                    if (want.colliding) hits_seen++;
                    if (want.status != STAT_OK) fault_seen++;
                    if (got.colliding !== want.colliding) begin
                        $error("colliding: expected %0d, got %0d", want.colliding, got.colliding);
                        errors++;
                    end
                    if (got.penetration !== want.penetration) begin
                        $error("penetration: expected %0d, got %0d",
                               want.penetration, got.penetration);
                        errors++;
                    end
                    if (got.normal_x !== want.normal_x) begin
                        $error("normal_x: expected %0d, got %0d", want.normal_x, got.normal_x);
                        errors++;
                    end
                    if (got.normal_y !== want.normal_y) begin
                        $error("normal_y: expected %0d, got %0d", want.normal_y, got.normal_y);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    task automatic queue_load(op_t op, logic signed [31:0] x, logic signed [31:0] y);
        load_t ld;
        ld.op = op;
        ld.x  = x;
        ld.y  = y;
        pending_loads.push_back(ld);
    endtask

    function automatic logic signed [31:0] jitter(logic signed [31:0] c, int unsigned span);
        return c + $signed($urandom_range(0, 2 * span)) - $signed(span);
    endfunction

    function automatic int unsigned pick_count();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(7, NV) : $urandom_range(3, 6);
    endfunction

    // One polygon pair: mostly well-formed, with a share of overflow and noise.
    task automatic queue_pair();
        int unsigned       kind = $urandom_range(0, 99);
        int unsigned       na, nb, span;
        bit                wild;
        logic signed [31:0] cax, cay, cbx, cby;
        span = $urandom_range(1, 4) << FRAC_BITS;
        wild = ($urandom_range(0, 9) == 0);
        cax  = jitter(0, 6 << FRAC_BITS);
        cay  = jitter(0, 6 << FRAC_BITS);
        cbx  = jitter(cax, 3 << FRAC_BITS);
        cby  = jitter(cay, 3 << FRAC_BITS);
        if (kind < 80) begin
            na = pick_count();
            nb = pick_count();
        end else if (kind < 90) begin
            // one store overfills
            na = $urandom_range(0, 1) ? NV + $urandom_range(1, 3) : pick_count();
            nb = (na <= NV) ? NV + $urandom_range(1, 3) : $urandom_range(0, 5);
        end else begin
            na = $urandom_range(0, 4);
            nb = $urandom_range(0, 4);
            wild = 1'b1;
        end
        for (int i = 0; i < na; i++)
            if (wild) queue_load(OP_VTX_FIRST, $urandom, $urandom);
            else      queue_load(OP_VTX_FIRST, jitter(cax, span), jitter(cay, span));
        for (int i = 0; i < nb; i++)
            if (wild) queue_load(OP_VTX_SECOND, $urandom, $urandom);
            else      queue_load(OP_VTX_SECOND, jitter(cbx, span), jitter(cby, span));
        if ($urandom_range(0, 9) < 8) begin
            if (wild) queue_load(OP_POS_FIRST, $urandom, $urandom);
            else      queue_load(OP_POS_FIRST, cax, cay);
        end
        if (wild) queue_load(OP_START, $urandom, $urandom);
        else      queue_load(OP_START, cbx, cby);
    endtask

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;
    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;

    initial begin
        // start with empty stores: too few vertices
        queue_load(OP_START, 0, 0);
        // two overlapping squares
        queue_load(OP_VTX_FIRST, 0, 0);
        queue_load(OP_VTX_FIRST, 2 * ONE, 0);
        queue_load(OP_VTX_FIRST, 2 * ONE, 2 * ONE);
        queue_load(OP_VTX_FIRST, 0, 2 * ONE);
        queue_load(OP_VTX_SECOND, ONE, ONE);
        queue_load(OP_VTX_SECOND, 3 * ONE, ONE);
        queue_load(OP_VTX_SECOND, 3 * ONE, 3 * ONE);
        queue_load(OP_VTX_SECOND, ONE, 3 * ONE);
        queue_load(OP_POS_FIRST, 0, 0);
        queue_load(OP_START, ONE, ONE);
        // all edges zero length: no axis at all
        for (int i = 0; i < 3; i++) queue_load(OP_VTX_FIRST, ONE, ONE);
        for (int i = 0; i < 3; i++) queue_load(OP_VTX_SECOND, ONE, ONE);
        queue_load(OP_START, ONE, ONE);
        // coordinate extremes, large edges that need halving
        queue_load(OP_VTX_FIRST, CMIN, CMIN);
        queue_load(OP_VTX_FIRST, CMAX, CMIN);
        queue_load(OP_VTX_FIRST, 0, CMAX);
        queue_load(OP_VTX_SECOND, CMAX, CMAX);
        queue_load(OP_VTX_SECOND, CMIN, CMAX);
        queue_load(OP_VTX_SECOND, 0, CMIN);
        queue_load(OP_POS_FIRST, CMAX, CMIN);
        queue_load(OP_START, CMIN, CMAX);
        while (pending_loads.size() < 1350) queue_pair();
        total_loads = pending_loads.size();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_loads.size() == 0 && taken_loads == total_loads);
        wait (expected_contacts.size() == 0);
        // hold for stray results
        repeat (8000) @(posedge aclk);
        $display("covered %0d transfers, %0d contact results (%0d colliding, %0d error status)",
                 taken_loads, contacts_seen, hits_seen, fault_seen);
        if (errors == 0 && expected_contacts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/psat_pkg.sv
rtl/psat_mul.sv
rtl/psat_sqrt.sv
rtl/psat_div.sv
rtl/polygon_separating_axis_test.sv
verif/tb_top.sv
